// ===== rtl/core/flpbc_pkg.sv =====
// ---------------------------------------------------------------------------
// flpbc_pkg
// Shared widths, constants and the microprogram of the four-pole low-pass
// biquad cascade.
// ---------------------------------------------------------------------------
package flpbc_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;

  // Fixed-point layout: coefficients Q3.28, delay registers Q11.28.
  localparam int FRAC      = 28;
  localparam int DW        = 40;   // delay, section input and output width
  localparam int QW        = 44;   // width of one rounded product
  localparam int SW48      = 48;   // width of the delay update sums
  localparam int LO_BITS   = 20;   // low part of a split 40-bit operand
  localparam int MUL_W     = 32;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ACC_W     = 74;

  localparam logic [MUL_W-1:0] K07 = 32'd187904819;  // 0.7 in Q3.28

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_FF_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB_FIRST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FB_SECOND = 2'd2;

  localparam logic [30:0]        FF_GAIN_RST   = 31'd46830713;
  localparam logic signed [31:0] FB_FIRST_RST  = 32'sd187323388;
  localparam logic signed [31:0] FB_SECOND_RST = -32'sd106209172;

  // Microprogram layout
  localparam int NUM_STEPS  = 25;
  localparam int STEP_W     = $clog2(NUM_STEPS);
  localparam int SECT_LEN   = 10;
  localparam int SECT1_BASE = 4;
  localparam int SECT2_BASE = SECT1_BASE + SECT_LEN;
  localparam int LAST_STEP  = NUM_STEPS - 1;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_WAIT_IN,
    SEQ_WAIT_OUT
  } seq_t;

  typedef enum logic [2:0] {
    A_ZERO,
    A_SAMPLE,
    A_X_LO,
    A_X_HI,
    A_Y_LO,
    A_Y_HI
  } a_sel_t;

  typedef enum logic [1:0] {
    B_K07,
    B_GAIN,
    B_FB1,
    B_FB2
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD_IN,
    ACC_LOAD_FRAC,
    ACC_ADD_HI
  } acc_op_t;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_X_IN,
    WB_FY,
    WB_M1,
    WB_DELAY
  } wb_t;

  typedef struct packed {
    seq_t              seq;
    logic [STEP_W-1:0] target;
    logic              sect;
    a_sel_t            a_sel;
    b_sel_t            b_sel;
    acc_op_t           acc;
    wb_t               wb;
  } ucode_t;

  function automatic ucode_t mk(input seq_t seq, input logic sect, input a_sel_t a,
                                input b_sel_t b, input acc_op_t acc, input wb_t wb);
    ucode_t w;
    w.seq    = seq;
    w.target = '0;
    w.sect   = sect;
    w.a_sel  = a;
    w.b_sel  = b;
    w.acc    = acc;
    w.wb     = wb;
    return w;
  endfunction

  // One control word per step. Each biquad section runs the same ten words;
  // a multiply issued in one step is accumulated in the next.
  function automatic ucode_t ucode(input logic [STEP_W-1:0] s);
    logic              sect;
    logic [STEP_W-1:0] k;
    ucode_t            w;
    sect = (s >= STEP_W'(SECT2_BASE));
    k    = sect ? s - STEP_W'(SECT2_BASE) : s - STEP_W'(SECT1_BASE);
    w    = mk(SEQ_NEXT, 1'b0, A_ZERO, B_GAIN, ACC_HOLD, WB_NONE);
    if (s inside {[SECT1_BASE:LAST_STEP-1]}) begin
      case (k)
        STEP_W'(0): w = mk(SEQ_NEXT, sect, A_X_LO, B_GAIN, ACC_HOLD, WB_NONE);
        STEP_W'(1): w = mk(SEQ_NEXT, sect, A_X_HI, B_GAIN, ACC_LOAD_FRAC, WB_NONE);
        STEP_W'(2): w = mk(SEQ_NEXT, sect, A_ZERO, B_GAIN, ACC_ADD_HI, WB_NONE);
        STEP_W'(3): w = mk(SEQ_NEXT, sect, A_ZERO, B_GAIN, ACC_HOLD, WB_FY);
        STEP_W'(4): w = mk(SEQ_NEXT, sect, A_Y_LO, B_FB1, ACC_HOLD, WB_NONE);
        STEP_W'(5): w = mk(SEQ_NEXT, sect, A_Y_HI, B_FB1, ACC_LOAD_FRAC, WB_NONE);
        STEP_W'(6): w = mk(SEQ_NEXT, sect, A_Y_LO, B_FB2, ACC_ADD_HI, WB_NONE);
        STEP_W'(7): w = mk(SEQ_NEXT, sect, A_Y_HI, B_FB2, ACC_LOAD_FRAC, WB_M1);
        STEP_W'(8): w = mk(SEQ_NEXT, sect, A_ZERO, B_GAIN, ACC_ADD_HI, WB_NONE);
        STEP_W'(9): w = mk(SEQ_NEXT, sect, A_ZERO, B_GAIN, ACC_HOLD, WB_DELAY);
        default:    w = mk(SEQ_NEXT, sect, A_ZERO, B_GAIN, ACC_HOLD, WB_NONE);
      endcase
    end else begin
      case (s)
        STEP_W'(0): w = mk(SEQ_WAIT_IN, 1'b0, A_ZERO, B_K07, ACC_HOLD, WB_NONE);
        STEP_W'(1): w = mk(SEQ_NEXT, 1'b0, A_SAMPLE, B_K07, ACC_HOLD, WB_NONE);
        STEP_W'(2): w = mk(SEQ_NEXT, 1'b0, A_ZERO, B_K07, ACC_LOAD_IN, WB_NONE);
        STEP_W'(3): w = mk(SEQ_NEXT, 1'b0, A_ZERO, B_K07, ACC_HOLD, WB_X_IN);
        STEP_W'(LAST_STEP): begin
          w        = mk(SEQ_WAIT_OUT, 1'b1, A_ZERO, B_GAIN, ACC_HOLD, WB_NONE);
          w.target = '0;
        end
        default:    w = mk(SEQ_NEXT, 1'b0, A_ZERO, B_GAIN, ACC_HOLD, WB_NONE);
      endcase
    end
    return w;
  endfunction

  // Saturate a delay update sum to the 40-bit delay range.
  function automatic logic signed [DW-1:0] sat40(input logic signed [SW48-1:0] v);
    logic signed [DW-1:0] r;
    if (v[SW48-1:DW-1] == '0 || v[SW48-1:DW-1] == '1) begin
      r = v[DW-1:0];
    end else if (v[SW48-1]) begin
      r = {1'b1, {(DW-1){1'b0}}};
    end else begin
      r = {1'b0, {(DW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/flpbc_in_if.sv =====
// ---------------------------------------------------------------------------
// flpbc_in_if
// Input sample channel: valid/ready handshake with one signed sample.
// ---------------------------------------------------------------------------
interface flpbc_in_if import flpbc_pkg::*; #(
  parameter int WIDTH = SAMPLE_WIDTH_DEF
);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink   (input valid, input in_sample, output ready);
endinterface

// ===== rtl/core/flpbc_out_if.sv =====
// ---------------------------------------------------------------------------
// flpbc_out_if
// Output sample channel: valid/ready handshake with one signed sample.
// ---------------------------------------------------------------------------
interface flpbc_out_if import flpbc_pkg::*; #(
  parameter int WIDTH = SAMPLE_WIDTH_DEF
);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink   (input valid, input out_sample, output ready);
endinterface

// ===== rtl/core/four_pole_lowpass_biquad_cascade_unit.sv =====
// A four-pole low-pass filter made of two identical biquad sections in
// transposed direct form II, run by a 25-step microprogram over one shared
// 32x32 multiplier and a 74-bit accumulator. Each sample runs through the
// steps from its input transfer until its result is registered and the
// sequencer is free again; only then is a new sample taken. The steps hold
// six coefficient products, each over a 40-bit operand taken in two halves,
// plus the input scaling and the delay updates. The result sits in an
// output register, so the next sample is taken while it waits; only when
// that register is still full at the end of the following sample does the
// sequencer hold. Coefficients must be written through the configuration
// port only while the filter is idle; the block does not enforce this.
// ---------------------------------------------------------------------------
// four_pole_lowpass_biquad_cascade_unit
// Microcoded fixed-point cascade of two low-pass biquads with output clip.
// ---------------------------------------------------------------------------
module four_pole_lowpass_biquad_cascade_unit import flpbc_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  flpbc_in_if.sink              in_ch,
  flpbc_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int FB     = SAMPLE_WIDTH - 1;
  localparam int RND_SH = (FB < FRAC) ? FRAC - FB : 1;
  localparam int UP_SH  = (FB > FRAC) ? FB - FRAC : 0;

  localparam logic signed [ACC_W-1:0] RND_FRAC = ACC_W'(1) <<< (FRAC - 1);
  localparam logic signed [ACC_W-1:0] RND_IN   = ACC_W'(1) <<< (FB - 1);
  localparam logic signed [DW-1:0]    ONE      = 40'sh00_1000_0000;
  localparam logic signed [63:0]      SMAX     = (64'sd1 <<< FB) - 64'sd1;
  localparam logic signed [63:0]      SMIN     = -(64'sd1 <<< FB);
  localparam logic signed [63:0]      OUT_RND  = 64'sd1 <<< (RND_SH - 1);

  // Configuration registers
  logic [30:0]        ff_gain;
  logic signed [31:0] fb_first;
  logic signed [31:0] fb_second;

  // Sequencer
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ucode_t            uw;
  logic              in_fire;
  logic              load_out;
  logic              out_valid;

  // Datapath
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic signed [MUL_W-1:0]        op_a;
  logic signed [MUL_W-1:0]        op_b;
  logic signed [PROD_W-1:0]       prod;
  logic signed [ACC_W-1:0]        acc;
  logic signed [QW-1:0]           q_val;
  logic signed [DW-1:0]           x;
  logic signed [DW-1:0]           y;
  logic signed [QW-1:0]           f;
  logic signed [QW-1:0]           m1;
  logic signed [DW-1:0]           da [2];
  logic signed [DW-1:0]           db [2];
  logic signed [DW-1:0]           y_clip;
  logic signed [63:0]             o_wide;
  logic signed [SAMPLE_WIDTH-1:0] out_value;
  logic signed [SAMPLE_WIDTH-1:0] out_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      ff_gain   <= FF_GAIN_RST;
      fb_first  <= FB_FIRST_RST;
      fb_second <= FB_SECOND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FF_GAIN:   ff_gain   <= cfg_data[30:0];
        REG_FB_FIRST:  fb_first  <= $signed(cfg_data);
        REG_FB_SECOND: fb_second <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign uw          = ucode(step);
  assign in_ch.ready = (uw.seq == SEQ_WAIT_IN);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign load_out    = (uw.seq == SEQ_WAIT_OUT) && (!out_valid || out_ch.ready);

  always_comb begin
    step_next = step;
    case (uw.seq)
      SEQ_WAIT_IN:  if (in_ch.valid) step_next = step + STEP_W'(1);
      SEQ_WAIT_OUT: if (load_out) step_next = uw.target;
      SEQ_NEXT:     step_next = step + STEP_W'(1);
      default:      step_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Operand selection: a 40-bit value enters the multiplier as an unsigned
  // low half and a signed high half, recombined in the accumulator.
  always_comb begin
    case (uw.a_sel)
      A_SAMPLE: op_a = MUL_W'(sample);
      A_X_LO:   op_a = $signed(MUL_W'(x[LO_BITS-1:0]));
      A_X_HI:   op_a = MUL_W'($signed(x[DW-1:LO_BITS]));
      A_Y_LO:   op_a = $signed(MUL_W'(y[LO_BITS-1:0]));
      A_Y_HI:   op_a = MUL_W'($signed(y[DW-1:LO_BITS]));
      default:  op_a = '0;
    endcase
    case (uw.b_sel)
      B_K07:   op_b = $signed(K07);
      B_GAIN:  op_b = $signed({1'b0, ff_gain});
      B_FB1:   op_b = fb_first;
      B_FB2:   op_b = fb_second;
      default: op_b = '0;
    endcase
  end

  assign q_val = QW'(acc >>> FRAC);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample <= SAMPLE_WIDTH'(in_ch.in_sample);
    end
    prod <= op_a * op_b;
    case (uw.acc)
      ACC_LOAD_IN:   acc <= ACC_W'(prod) + RND_IN;
      ACC_LOAD_FRAC: acc <= ACC_W'(prod) + RND_FRAC;
      ACC_ADD_HI:    acc <= acc + (ACC_W'(prod) <<< LO_BITS);
      default: ;
    endcase
    case (uw.wb)
      WB_X_IN: x <= DW'(acc >>> FB);
      WB_FY: begin
        f <= q_val;
        y <= sat40(SW48'(q_val) + SW48'(da[uw.sect]));
      end
      WB_M1: m1 <= q_val;
      WB_DELAY: begin
        x <= y;
      end
      default: ;
    endcase
  end

  // Delay registers reset to zero and change only at the end of a section.
  always_ff @(posedge clk) begin
    if (rst) begin
      da[0] <= '0;
      da[1] <= '0;
      db[0] <= '0;
      db[1] <= '0;
    end else if (uw.wb == WB_DELAY) begin
      da[uw.sect] <= sat40(SW48'(db[uw.sect]) + (SW48'(f) <<< 1) + SW48'(m1));
      db[uw.sect] <= sat40(SW48'(f) + SW48'(q_val));
    end
  end

  // Clip to full scale, then bring to the sample format.
  always_comb begin
    if (y > ONE) begin
      y_clip = ONE;
    end else if (y < -ONE) begin
      y_clip = -ONE;
    end else begin
      y_clip = y;
    end
    if (FB < FRAC) begin
      o_wide = (64'(y_clip) + OUT_RND) >>> RND_SH;
    end else if (FB == FRAC) begin
      o_wide = 64'(y_clip);
    end else begin
      o_wide = 64'(y_clip) <<< UP_SH;
    end
    if (o_wide > SMAX) begin
      out_value = SAMPLE_WIDTH'(SMAX);
    end else if (o_wide < SMIN) begin
      out_value = SAMPLE_WIDTH'(SMIN);
    end else begin
      out_value = SAMPLE_WIDTH'(o_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample <= out_value;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.out_sample = out_sample;

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> step == STEP_W'(1))
    else $error("input transfer did not start the microprogram");

  a_out_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(step) == STEP_W'(LAST_STEP))
    else $error("output became valid outside the final step");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= STEP_W'(LAST_STEP))
    else $error("step counter beyond the microprogram");

  a_delay_idle: assert property (@(posedge clk) disable iff (rst)
    step == '0 |=> $stable(da[0]) && $stable(da[1]) && $stable(db[0]) && $stable(db[1]))
    else $error("delay registers changed while idle");
`endif

endmodule

// ===== tb/four_pole_lowpass_biquad_cascade_unit_tb.sv =====
// ---------------------------------------------------------------------------
// four_pole_lowpass_biquad_cascade_unit_tb
// Self-checking bench for the four-pole low-pass cascade. A bit-exact
// fixed-point model of the two biquad sections predicts every output sample.
// Each prediction is queued when its input transfer happens, and each output
// transfer is compared with the oldest prediction. Directed tests cover the
// full-scale samples, coefficient extremes with saturating delays and an
// unused register index. Random streams follow under several coefficient
// sets, with random gaps on both channels.
// ---------------------------------------------------------------------------
module four_pole_lowpass_biquad_cascade_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import flpbc_pkg::*;

  localparam int SW          = SAMPLE_WIDTH_DEF;
  localparam int IDLE_PCT    = 31;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int IN_SHIFT    = SW - 1;
  localparam int OUT_SHIFT   = FRAC - (SW - 1);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef logic signed [95:0] wide_t;

  localparam wide_t HALF_Q    = wide_t'(1) <<< (FRAC - 1);
  localparam wide_t UNITY     = wide_t'(1) <<< FRAC;
  localparam wide_t DELAY_MAX = (wide_t'(1) <<< (DW - 1)) - 1;
  localparam wide_t DELAY_MIN = -(wide_t'(1) <<< (DW - 1));
  localparam wide_t SMP_MAX   = (wide_t'(1) <<< (SW - 1)) - 1;
  localparam wide_t SMP_MIN   = -(wide_t'(1) <<< (SW - 1));
  localparam logic signed [SW-1:0] FULL_POS = SMP_MAX[SW-1:0];
  localparam logic signed [SW-1:0] FULL_NEG = SMP_MIN[SW-1:0];

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  flpbc_in_if  #(.WIDTH(SW)) in_ch ();
  flpbc_out_if #(.WIDTH(SW)) out_ch ();

  four_pole_lowpass_biquad_cascade_unit #(.SAMPLE_WIDTH(SW)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Filter model state: coefficients and the two delay pairs.
  logic [30:0]          coef_gain;
  logic signed [31:0]   coef_b1;
  logic signed [31:0]   coef_b2;
  logic signed [DW-1:0] dly_a [2];
  logic signed [DW-1:0] dly_b [2];

  logic signed [SW-1:0] pending_filtered [$];
  logic signed [SW-1:0] want_sample;
  int                   mismatch_count = 0;
  int                   cycle_count = 0;
  bit                   no_idle = 1'b0;
  int                   walk = 0;

  function automatic wide_t mul_round(input wide_t a, input wide_t c);
    return (a * c + HALF_Q) >>> FRAC;
  endfunction

  function automatic wide_t clamp_delay(input wide_t v);
    if (v > DELAY_MAX) return DELAY_MAX;
    if (v < DELAY_MIN) return DELAY_MIN;
    return v;
  endfunction

  // One transposed direct form II section; k selects its delay pair.
  function automatic wide_t biquad_step(input int k, input wide_t x);
    wide_t f;
    wide_t y;
    wide_t na;
    wide_t nb;
    f  = mul_round(x, wide_t'(coef_gain));
    y  = clamp_delay(f + wide_t'(dly_a[k]));
    na = clamp_delay(wide_t'(dly_b[k]) + 2 * f + mul_round(y, wide_t'(coef_b1)));
    nb = clamp_delay(f + mul_round(y, wide_t'(coef_b2)));
    dly_a[k] = na[DW-1:0];
    dly_b[k] = nb[DW-1:0];
    return y;
  endfunction

  function automatic logic signed [SW-1:0] lowpass_predict(input logic signed [SW-1:0] s);
    wide_t x;
    wide_t y;
    wide_t o;
    x = (wide_t'(s) * wide_t'(K07) + (wide_t'(1) <<< (IN_SHIFT - 1))) >>> IN_SHIFT;
    y = biquad_step(0, x);
    y = biquad_step(1, y);
    if (y > UNITY) y = UNITY;
    if (y < -UNITY) y = -UNITY;
    o = (y + (wide_t'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (o > SMP_MAX) o = SMP_MAX;
    if (o < SMP_MIN) o = SMP_MIN;
    return o[SW-1:0];
  endfunction

  // Output side: random back-pressure, switched off during the steady stretch.
  always @(posedge clk) begin
    out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_filtered.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: unexpected output sample %0d", $realtime, out_ch.out_sample);
        mismatch_count++;
      end else begin
        want_sample = pending_filtered.pop_front();
        if (out_ch.out_sample !== want_sample) begin
          if (mismatch_count < 10)
            $display("%0t: out_sample mismatch, expected %0d, got %0d",
                     $realtime, want_sample, out_ch.out_sample);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_sample(input logic signed [SW-1:0] s);
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid     <= 1'b1;
    in_ch.in_sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    pending_filtered.push_back(lowpass_predict(s));
  endtask

  // Stop sending and wait until every predicted sample has been transferred.
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending_filtered.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_FF_GAIN:   coef_gain = data[30:0];
      REG_FB_FIRST:  coef_b1   = data;
      REG_FB_SECOND: coef_b2   = data;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_reset;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_FF_GAIN;
    cfg_data  <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.in_sample <= '0;
    coef_gain = FF_GAIN_RST;
    coef_b1   = FB_FIRST_RST;
    coef_b2   = FB_SECOND_RST;
    for (int k = 0; k < 2; k++) begin
      dly_a[k] = '0;
      dly_b[k] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
  endtask

  // Full-scale and small samples through the reset coefficients, then an impulse.
  task automatic test_reset_coefficients;
    send_sample('0);
    send_sample(FULL_POS);
    send_sample(FULL_NEG);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
    send_sample(FULL_POS);
    send_sample('0);
    send_sample('0);
  endtask

  // Extreme coefficients drive the delays into saturation and the output into clip.
  task automatic test_saturation;
    drain();
    write_reg(REG_FF_GAIN, 32'hFFFF_FFFF);
    write_reg(REG_FB_FIRST, 32'h7FFF_FFFF);
    write_reg(REG_FB_SECOND, 32'h7FFF_FFFF);
    send_sample(FULL_POS);
    send_sample(FULL_POS);
    send_sample(FULL_NEG);
    send_sample(FULL_NEG);
    send_sample(FULL_POS);
    drain();
    write_reg(REG_FB_FIRST, 32'h8000_0000);
    write_reg(REG_FB_SECOND, 32'h8000_0000);
    send_sample(FULL_NEG);
    send_sample(FULL_POS);
    send_sample('0);
    drain();
    write_reg(REG_FF_GAIN, 32'h0000_0000);
    send_sample(FULL_POS);
    send_sample(FULL_NEG);
  endtask

  // A write to the unused index must leave every coefficient alone.
  task automatic test_unused_index;
    drain();
    write_reg(REG_FF_GAIN, {1'b0, FF_GAIN_RST});
    write_reg(REG_FB_FIRST, FB_FIRST_RST);
    write_reg(REG_FB_SECOND, FB_SECOND_RST);
    write_reg(REG_UNUSED, $urandom());
    send_sample(FULL_POS);
    send_sample(16'sd1234);
    send_sample(FULL_NEG);
  endtask

  // Coefficients for one phase: reset values, a random stable filter, or any bits.
  task automatic load_phase_coefficients(input int kind);
    longint b2;
    longint lim;
    longint b1;
    if (kind == 0) begin
      write_reg(REG_FF_GAIN, {1'b0, FF_GAIN_RST});
      write_reg(REG_FB_FIRST, FB_FIRST_RST);
      write_reg(REG_FB_SECOND, FB_SECOND_RST);
    end else if (kind == 1) begin
      // Poles stay inside the unit circle when |b2| < 1 and |b1| < 1 - b2.
      b2  = longint'($urandom_range(335_000_000)) - 255_000_000;
      lim = ((longint'(UNITY) - b2) * 95) / 100;
      b1  = longint'($urandom_range(32'(2 * lim))) - lim;
      write_reg(REG_FF_GAIN, $urandom_range(1 << 25));
      write_reg(REG_FB_FIRST, b1[31:0]);
      write_reg(REG_FB_SECOND, b2[31:0]);
    end else begin
      write_reg(REG_FF_GAIN, $urandom());
      write_reg(REG_FB_FIRST, $urandom());
      write_reg(REG_FB_SECOND, $urandom());
    end
  endtask

  task automatic test_random_streams;
    int kinds [7] = '{0, 1, 1, 2, 1, 1, 0};
    int pick;
    logic signed [SW-1:0] s;
    for (int p = 0; p < 7; p++) begin
      drain();
      load_phase_coefficients(kinds[p]);
      no_idle = (p == 4);
      for (int n = 0; n < 250; n++) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          // Audio-like random walk.
          walk = walk + int'($urandom_range(4000)) - 2000;
          if (walk > 32767) walk = 32767;
          if (walk < -32768) walk = -32768;
          s = walk[SW-1:0];
        end else if (pick < 90) begin
          s = SW'($urandom());
        end else if (pick < 95) begin
          s = ($urandom_range(1) == 1) ? FULL_POS : FULL_NEG;
        end else begin
          s = '0;
        end
        send_sample(s);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    apply_reset();
    test_reset_coefficients();
    test_saturation();
    test_unused_index();
    test_random_streams();
    drain();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_filtered.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
